// File: rtl/core/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants for the slope line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

    localparam int CFG_W      = 13;
    localparam int COLOR_W    = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FB_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FB_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FB_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FB_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/slr_div.sv
// ----------------------------------------------------------------------------
// slr_div
// Bit-serial restoring divider for the slope: (num << (Q_W-1)) / den, num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_div #(
    parameter int MAG_W = 13,
    parameter int Q_W   = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MAG_W-1:0]  num,
    input  wire logic [MAG_W-1:0]  den,
    output logic      [Q_W-1:0]    quot,
    output slr_pkg::div_stat_t     stat
);
    import slr_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] den_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             first_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic             ge;
    logic [MAG_W-1:0] rem_next;

    // first step weighs the numerator itself (top quotient bit)
    always_comb
    begin
        trial    = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[Q_W-2:0], ge};
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/slr_mac.sv
// ----------------------------------------------------------------------------
// slr_mac
// Registered signed multiply-add, y = a * b + c, shared by setup and stepping.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_mac #(
    parameter int A_W = 18,
    parameter int B_W = 14,
    parameter int Y_W = 32
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic signed [A_W-1:0]  a,
    input  wire logic signed [B_W-1:0]  b,
    input  wire logic signed [Y_W-1:0]  c,
    output logic signed      [Y_W-1:0]  y
);
    logic signed [A_W+B_W-1:0] prod;
    logic signed [Y_W-1:0]     y_reg;

    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= Y_W'(prod) + c;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// File: rtl/core/slope_line_rasterizer.sv
// ----------------------------------------------------------------------------
// slope_line_rasterizer
// Fixed-point DDA line stepper: start loads a line, each tick on an active line emits one pixel.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 contents
//  s_axis    in   tvalid/tready             tuser action, tdata endpoints+color
//  m_axis    out  tvalid/tready             tdata pixel, tuser plot, tlast last
//  cfg       in   cfg_we                    cfg_addr, cfg_wdata
//
//  Start request: runs setup and orientation, then the bit-serial slope
//  divider, then one multiply-add for the intercept.
//  Tick request: on an active line, one pass through the shared
//  multiply-add, then the pixel step; no effect when no line is active.
//  A finished pixel waits in the output register; a new request is taken
//  meanwhile. A tick holds in the pixel step while that register is full.
//  Reset: async, active low; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module slope_line_rasterizer #(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // x_from, y_from, x_to, y_to, pen_color (low to high), zero pad
    input  wire logic [((4*COORD_BITS+slr_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  wire logic                                  s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // pixel_x, pixel_y, pixel_color (low to high), zero pad
    output logic [((2*COORD_BITS+slr_pkg::COLOR_W+7)/8)*8-1:0] m_axis_tdata,
    // plot
    output logic                                       m_axis_tuser,
    output logic                                       m_axis_tlast,
    input  wire logic                                  cfg_we,
    input  wire logic [slr_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [slr_pkg::CFG_W-1:0]             cfg_wdata
);
    import slr_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int OUT_W  = ((2*C + COLOR_W + 7) / 8) * 8;
    localparam int SL_W   = F + 2;
    localparam int MJ_W   = C + 1;
    localparam int ACC_W  = C + F + 3;
    localparam int Q_W    = F + 1;
    localparam int QT_W   = ACC_W - F;
    localparam int CMP_W  = (QT_W > CFG_W + 1) ? QT_W : CFG_W + 1;
    localparam logic signed [SL_W-1:0] ONE = SL_W'(1) << F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ORIENT,
        ST_DIV,
        ST_ICPT,
        ST_ICPT_WB,
        ST_PIX
    } state_t;

    function automatic logic in_width(input logic signed [CMP_W-1:0] v,
                                      input logic [CMP_W-1:0] w);
        return (v > 0) && (v < $signed(w));
    endfunction

    state_t state_reg;

    logic [CFG_W-1:0] fb_width_reg;
    logic [CFG_W-1:0] fb_height_reg;

    logic line_active_reg;
    logic x_major_reg;
    logic m_valid_reg;
    logic [C-1:0]       out_px_reg;
    logic [C-1:0]       out_py_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_plot_reg;
    logic               out_last_reg;

    logic signed [C-1:0]     ax_reg, ay_reg, bx_reg, by_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic signed [MJ_W-1:0]  dx_reg, dy_reg;
    logic                    neg_reg;
    logic                    den_zero_reg;
    logic signed [C-1:0]     step_coord_reg, end_coord_reg;
    logic signed [C-1:0]     anchor_major_reg, anchor_minor_reg;
    logic signed [SL_W-1:0]  slope_reg;
    logic signed [ACC_W-1:0] intercept_reg;

    // request unpack
    logic signed [C-1:0] in_x_from, in_y_from, in_x_to, in_y_to;
    logic [COLOR_W-1:0]  in_color;
    logic                req_acc, start_req, tick_req;

    assign in_x_from = s_axis_tdata[0*C +: C];
    assign in_y_from = s_axis_tdata[1*C +: C];
    assign in_x_to   = s_axis_tdata[2*C +: C];
    assign in_y_to   = s_axis_tdata[3*C +: C];
    assign in_color  = s_axis_tdata[4*C +: COLOR_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign req_acc       = s_axis_tvalid && s_axis_tready;
    assign start_req     = req_acc && !s_axis_tuser;
    assign tick_req      = req_acc && s_axis_tuser;

    logic [CMP_W-1:0] w_cmp;
    assign w_cmp = CMP_W'(fb_width_reg);

    // orientation
    logic signed [MJ_W-1:0] adx;
    logic                   xm;
    logic signed [C-1:0]    lo_x, hi_x, step_init, end_init;
    logic                   active_init;
    logic [C-1:0]           div_num, div_den;

    always_comb
    begin
        adx       = dx_reg[MJ_W-1] ? -dx_reg : dx_reg;
        xm        = adx > dy_reg;
        lo_x      = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        hi_x      = (ax_reg < bx_reg) ? bx_reg : ax_reg;
        step_init = xm ? lo_x : ay_reg;
        end_init  = xm ? hi_x : by_reg;
        active_init = (step_init < end_init) &&
                      in_width(CMP_W'(xm ? step_init : ax_reg), w_cmp);
        div_num   = xm ? dy_reg[C-1:0] : adx[C-1:0];
        div_den   = xm ? adx[C-1:0] : dy_reg[C-1:0];
    end

    // divider
    logic [Q_W-1:0]          div_quot;
    div_stat_t               div_stat;
    logic                    div_start;
    logic signed [SL_W-1:0]  q_ext;

    assign div_start = (state_reg == ST_ORIENT);
    assign q_ext     = $signed(SL_W'(div_quot));

    slr_div #(
        .MAG_W (C),
        .Q_W   (Q_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // shared multiply-add: intercept at setup, minor coordinate per tick
    logic                    mac_en;
    logic signed [MJ_W-1:0]  mac_b;
    logic signed [ACC_W-1:0] mac_c;
    logic signed [ACC_W-1:0] mac_y;
    logic                    icpt_sel;

    assign icpt_sel = (state_reg == ST_ICPT);
    assign mac_en   = icpt_sel || (tick_req && line_active_reg);
    assign mac_b    = icpt_sel ? -MJ_W'(anchor_major_reg) : MJ_W'(step_coord_reg);
    assign mac_c    = icpt_sel ? (ACC_W'(anchor_minor_reg) <<< F) : intercept_reg;

    slr_mac #(
        .A_W (SL_W),
        .B_W (MJ_W),
        .Y_W (ACC_W)
    ) u_mac (
        .clk (clk),
        .en  (mac_en),
        .a   (slope_reg),
        .b   (mac_b),
        .c   (mac_c),
        .y   (mac_y)
    );

    // pixel evaluation, minor = mac_y / 2^F truncated toward zero
    logic                    rnd;
    logic signed [QT_W-1:0]  minor;
    logic signed [CMP_W-1:0] minor_cmp, step_cmp, py_cmp;
    logic signed [MJ_W-1:0]  nxt, end_ext;
    logic                    more, plot, pix_go;
    logic [C-1:0]            px, py;

    always_comb
    begin
        rnd       = mac_y[ACC_W-1] && (|mac_y[F-1:0]);
        minor     = QT_W'(mac_y >>> F) + QT_W'(rnd);
        minor_cmp = CMP_W'(minor);
        step_cmp  = CMP_W'(step_coord_reg);
        nxt       = MJ_W'(step_coord_reg) + MJ_W'(1);
        end_ext   = MJ_W'(end_coord_reg);
        more      = (nxt < end_ext) &&
                    (x_major_reg ? in_width(CMP_W'(nxt), w_cmp)
                                 : in_width(minor_cmp, w_cmp));
        px        = x_major_reg ? step_coord_reg : minor[C-1:0];
        py        = x_major_reg ? minor[C-1:0] : step_coord_reg;
        py_cmp    = x_major_reg ? minor_cmp : step_cmp;
        plot      = (py_cmp >= 0) && (py_cmp <= $signed(CMP_W'(fb_height_reg)));
        pix_go    = (state_reg == ST_PIX) && (!m_valid_reg || m_axis_tready);
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= FB_WIDTH_RST;
            fb_height_reg <= FB_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FB_WIDTH:  fb_width_reg  <= cfg_wdata;
                REG_FB_HEIGHT: fb_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            x_major_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            out_px_reg      <= '0;
            out_py_reg      <= '0;
            out_color_reg   <= '0;
            out_plot_reg    <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && !pix_go)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start_req)
                    begin
                        line_active_reg <= 1'b0;
                        state_reg       <= ST_SETUP;
                    end
                    else if (tick_req && line_active_reg)
                    begin
                        state_reg <= ST_PIX;
                    end
                end
                ST_SETUP:
                begin
                    state_reg <= ST_ORIENT;
                end
                ST_ORIENT:
                begin
                    x_major_reg     <= xm;
                    line_active_reg <= active_init;
                    state_reg       <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_ICPT;
                    end
                end
                ST_ICPT:
                begin
                    state_reg <= ST_ICPT_WB;
                end
                ST_ICPT_WB:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_PIX:
                begin
                    if (pix_go)
                    begin
                        m_valid_reg     <= 1'b1;
                        out_px_reg      <= px;
                        out_py_reg      <= py;
                        out_color_reg   <= color_reg;
                        out_plot_reg    <= plot;
                        out_last_reg    <= !more;
                        line_active_reg <= more;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // line datapath
    always_ff @(posedge clk)
    begin
        if (start_req)
        begin
            color_reg <= in_color;
            if (in_y_from >= in_y_to)
            begin
                ax_reg <= in_x_to;
                ay_reg <= in_y_to;
                bx_reg <= in_x_from;
                by_reg <= in_y_from;
            end
            else
            begin
                ax_reg <= in_x_from;
                ay_reg <= in_y_from;
                bx_reg <= in_x_to;
                by_reg <= in_y_to;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            dx_reg <= MJ_W'(bx_reg) - MJ_W'(ax_reg);
            dy_reg <= MJ_W'(by_reg) - MJ_W'(ay_reg);
        end
        if (state_reg == ST_ORIENT)
        begin
            neg_reg          <= dx_reg[MJ_W-1];
            den_zero_reg     <= (dy_reg == '0) && !xm;
            step_coord_reg   <= step_init;
            end_coord_reg    <= end_init;
            anchor_major_reg <= xm ? ax_reg : ay_reg;
            anchor_minor_reg <= xm ? ay_reg : ax_reg;
        end
        if ((state_reg == ST_DIV) && div_stat.done)
        begin
            slope_reg <= den_zero_reg ? '0 : (neg_reg ? -q_ext : q_ext);
        end
        if (state_reg == ST_ICPT_WB)
        begin
            intercept_reg <= mac_y;
        end
        if (pix_go)
        begin
            step_coord_reg <= nxt[C-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_color_reg, out_py_reg, out_px_reg});
    assign m_axis_tuser  = out_plot_reg;
    assign m_axis_tlast  = out_last_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ICPT) |-> ((slope_reg <= ONE) && (slope_reg >= -ONE)))
        else $error("slope magnitude above one");

    a_pix_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_PIX))
        else $error("pixel emitted outside pixel step");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tlast != line_active_reg))
        else $error("last flag disagrees with line state");

endmodule

`default_nettype wire
